>>> sv/lpd_pkg.sv
// Shared constants and width helpers for the Legendre evaluator.
package lpd_pkg;

  localparam int MAX_DEGREE = 63;
  localparam int FRAC_BITS  = 30;

  // port widths
  localparam int X_W      = 32;
  localparam int POLY_W   = 32;
  localparam int DERIV_W  = 42;
  localparam int DEGREE_W = 6;

  localparam logic [DEGREE_W-1:0] DEGREE_RST = DEGREE_W'(1);

  // P_j lies in [-1,1]: one integer bit plus sign
  function automatic int poly_w(input int frac_bits);
    return frac_bits + 2;
  endfunction

  // P'_j magnitude bound is N(N+1)/2
  function automatic int deriv_w(input int frac_bits, input int max_degree);
    return frac_bits + $clog2(max_degree * (max_degree + 1) / 2 + 1) + 1;
  endfunction

  function automatic int sel_w(input int max_degree);
    return $clog2(max_degree + 1);
  endfunction

endpackage

>>> sv/lpd_front.sv
// Entry stage: clamps the point, saturates the degree and seeds the recurrence.
module lpd_front #(
  parameter int MAX_DEGREE = lpd_pkg::MAX_DEGREE,
  parameter int FRAC_BITS  = lpd_pkg::FRAC_BITS
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic                                              en_i,
  input  logic                                              valid_i,
  input  logic signed [lpd_pkg::X_W-1:0]                    x_point_i,
  input  logic        [lpd_pkg::DEGREE_W-1:0]               degree_i,
  output logic                                              valid_o,
  output logic        [lpd_pkg::sel_w(MAX_DEGREE)-1:0]      n_o,
  output logic signed [lpd_pkg::poly_w(FRAC_BITS)-1:0]      x_o,
  output logic signed [lpd_pkg::poly_w(FRAC_BITS)-1:0]      pp_o,
  output logic signed [lpd_pkg::poly_w(FRAC_BITS)-1:0]      pc_o,
  output logic signed [lpd_pkg::deriv_w(FRAC_BITS, MAX_DEGREE)-1:0] dpp_o,
  output logic signed [lpd_pkg::deriv_w(FRAC_BITS, MAX_DEGREE)-1:0] dpc_o
);

  localparam int PW  = lpd_pkg::poly_w(FRAC_BITS);
  localparam int DW  = lpd_pkg::deriv_w(FRAC_BITS, MAX_DEGREE);
  localparam int NBW = lpd_pkg::sel_w(MAX_DEGREE);
  localparam int XW  = ((lpd_pkg::X_W > PW) ? lpd_pkg::X_W : PW) + 1;
  localparam int DCW = (NBW > lpd_pkg::DEGREE_W) ? NBW : lpd_pkg::DEGREE_W;

  localparam logic signed [XW-1:0] ONE_X = {{(XW-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
  localparam logic signed [PW-1:0] ONE_P = {{(PW-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
  localparam logic signed [DW-1:0] ONE_D = {{(DW-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

  logic signed [XW-1:0] x_ext;
  logic signed [PW-1:0] x_clamped;
  logic        [DCW-1:0] deg_ext;
  logic        [NBW-1:0] n_sat;

  logic                  valid_q;
  logic        [NBW-1:0] n_q;
  logic signed [PW-1:0]  x_q, pc_q;
  logic signed [DW-1:0]  dpc_q;

  always_comb begin
    x_ext = XW'(x_point_i);
    if (x_ext > ONE_X) begin
      x_clamped = ONE_P;
    end else if (x_ext < -ONE_X) begin
      x_clamped = -ONE_P;
    end else begin
      x_clamped = PW'(x_ext);
    end
    deg_ext = DCW'(degree_i);
    if (deg_ext > DCW'(MAX_DEGREE)) begin
      n_sat = NBW'(MAX_DEGREE);
    end else begin
      n_sat = NBW'(deg_ext);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // degree zero seeds (1, 0) and no cell will touch it
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q <= n_sat;
      x_q <= x_clamped;
      if (n_sat == '0) begin
        pc_q  <= ONE_P;
        dpc_q <= '0;
      end else begin
        pc_q  <= x_clamped;
        dpc_q <= ONE_D;
      end
    end
  end

  assign valid_o = valid_q;
  assign n_o     = n_q;
  assign x_o     = x_q;
  assign pp_o    = ONE_P;
  assign pc_o    = pc_q;
  assign dpp_o   = '0;
  assign dpc_o   = dpc_q;

endmodule

>>> sv/lpd_cell.sv
// One recurrence step j -> j+1, five register stages deep.
module lpd_cell #(
  parameter int J          = 1,
  parameter int MAX_DEGREE = lpd_pkg::MAX_DEGREE,
  parameter int FRAC_BITS  = lpd_pkg::FRAC_BITS
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic                                              en_i,
  input  logic                                              valid_i,
  input  logic        [lpd_pkg::sel_w(MAX_DEGREE)-1:0]      n_i,
  input  logic signed [lpd_pkg::poly_w(FRAC_BITS)-1:0]      x_i,
  input  logic signed [lpd_pkg::poly_w(FRAC_BITS)-1:0]      pp_i,
  input  logic signed [lpd_pkg::poly_w(FRAC_BITS)-1:0]      pc_i,
  input  logic signed [lpd_pkg::deriv_w(FRAC_BITS, MAX_DEGREE)-1:0] dpp_i,
  input  logic signed [lpd_pkg::deriv_w(FRAC_BITS, MAX_DEGREE)-1:0] dpc_i,
  output logic                                              valid_o,
  output logic        [lpd_pkg::sel_w(MAX_DEGREE)-1:0]      n_o,
  output logic signed [lpd_pkg::poly_w(FRAC_BITS)-1:0]      x_o,
  output logic signed [lpd_pkg::poly_w(FRAC_BITS)-1:0]      pp_o,
  output logic signed [lpd_pkg::poly_w(FRAC_BITS)-1:0]      pc_o,
  output logic signed [lpd_pkg::deriv_w(FRAC_BITS, MAX_DEGREE)-1:0] dpp_o,
  output logic signed [lpd_pkg::deriv_w(FRAC_BITS, MAX_DEGREE)-1:0] dpc_o
);

  localparam int PW  = lpd_pkg::poly_w(FRAC_BITS);
  localparam int MW  = FRAC_BITS + 1;
  localparam int DW  = lpd_pkg::deriv_w(FRAC_BITS, MAX_DEGREE);
  localparam int DXW = DW + 2;
  localparam int NBW = lpd_pkg::sel_w(MAX_DEGREE);
  localparam int PRW = 2 * MW;
  // dividend |num| + d/2 stays below 3*MAX_DEGREE ones
  localparam int AW  = FRAC_BITS + $clog2(3 * MAX_DEGREE);
  localparam int NW  = AW + 1;
  localparam int AL  = AW / 2;
  localparam int AH  = AW - AL;
  localparam int SW  = 2 * AW;
  localparam int D   = J + 1;
  localparam int HALF_D = D / 2;
  localparam int DBW = $clog2(D + 1);
  localparam int QDW = AW + DBW;

  localparam longint unsigned RECIP = (64'd1 << AW) / D;
  localparam logic [AW-1:0] R     = AW'(RECIP);
  localparam logic [AH-1:0] R_H   = R[AW-1:AL];
  localparam logic [AL-1:0] R_L   = R[AL-1:0];

  localparam longint DLIM_L = longint'((J + 1) * (J + 2) / 2) << FRAC_BITS;
  localparam logic signed [DXW-1:0] DLIM  = DXW'(DLIM_L);
  localparam logic signed [DXW-1:0] C2_D  = DXW'(2 * J + 1);
  localparam logic signed [NW-1:0]  C2_N  = NW'(2 * J + 1);
  localparam logic signed [NW-1:0]  CJ_N  = NW'(J);
  localparam logic [MW-1:0]  ONE_M  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [AW-1:0]  ONE_A  = AW'(ONE_M);
  localparam logic [PRW-1:0] HALF_P = PRW'(1) << (FRAC_BITS - 1);

  // stage 1: x * P_j magnitude product
  logic                  s1_valid_q, s1_act_q, s1_neg_q;
  logic        [NBW-1:0] s1_n_q;
  logic signed [PW-1:0]  s1_x_q, s1_pp_q, s1_pc_q;
  logic signed [DW-1:0]  s1_dpp_q, s1_dpc_q;
  logic        [PRW-1:0] s1_prod_q;
  logic        [MW-1:0]  ua, ub;

  always_comb begin
    ua = x_i[PW-1]  ? MW'(-x_i)  : MW'(x_i);
    ub = pc_i[PW-1] ? MW'(-pc_i) : MW'(pc_i);
  end

  // stage 2: rounding, numerator and derivative update
  logic                  s2_valid_q, s2_act_q, s2_neg_q;
  logic        [NBW-1:0] s2_n_q;
  logic signed [PW-1:0]  s2_x_q, s2_pp_q, s2_pc_q;
  logic signed [DW-1:0]  s2_dpp_q, s2_dpc_q;
  logic        [AW-1:0]  s2_a_q;
  logic        [PRW-1:0] prod_rnd;
  logic        [MW-1:0]  t_mag;
  logic signed [PW-1:0]  t_val;
  logic signed [NW-1:0]  num;
  logic        [AW-1:0]  a_val;
  logic signed [DXW-1:0] dsum, dclamp;

  always_comb begin
    prod_rnd = s1_prod_q + HALF_P;
    t_mag    = MW'(prod_rnd >> FRAC_BITS);
    t_val    = s1_neg_q ? -$signed(PW'(t_mag)) : $signed(PW'(t_mag));
    num      = C2_N * NW'(t_val) - CJ_N * NW'(s1_pp_q);
    a_val    = (num[NW-1] ? AW'(-num) : AW'(num)) + AW'(HALF_D);
    dsum     = C2_D * DXW'(s1_pc_q) + DXW'(s1_dpp_q);
    if (dsum > DLIM) begin
      dclamp = DLIM;
    end else if (dsum < -DLIM) begin
      dclamp = -DLIM;
    end else begin
      dclamp = dsum;
    end
  end

  // stage 3: reciprocal partial products
  logic                  s3_valid_q, s3_act_q, s3_neg_q;
  logic        [NBW-1:0] s3_n_q;
  logic signed [PW-1:0]  s3_x_q, s3_pp_q, s3_pc_q;
  logic signed [DW-1:0]  s3_dpp_q, s3_dpc_q;
  logic        [AW-1:0]  s3_a_q;
  logic      [2*AH-1:0]  s3_hh_q;
  logic        [AW-1:0]  s3_hl_q, s3_lh_q;
  logic      [2*AL-1:0]  s3_ll_q;

  // stage 4: quotient estimate, low by at most one
  logic                  s4_valid_q, s4_act_q, s4_neg_q;
  logic        [NBW-1:0] s4_n_q;
  logic signed [PW-1:0]  s4_x_q, s4_pp_q, s4_pc_q;
  logic signed [DW-1:0]  s4_dpp_q, s4_dpc_q;
  logic        [AW-1:0]  s4_a_q, s4_q0_q;
  logic        [SW-1:0]  qsum;

  always_comb begin
    qsum = (SW'(s3_hh_q) << (2 * AL)) + (SW'(s3_hl_q) << AL) + (SW'(s3_lh_q) << AL)
         + SW'(s3_ll_q);
  end

  // stage 5: correction, clamp, sign
  logic                  s5_valid_q;
  logic        [NBW-1:0] s5_n_q;
  logic signed [PW-1:0]  s5_x_q, s5_pp_q, s5_pc_q;
  logic signed [DW-1:0]  s5_dpp_q, s5_dpc_q;
  logic        [QDW-1:0] qd;
  logic        [AW-1:0]  rem, q_fix, q_sat;
  logic signed [PW-1:0]  p_next;

  always_comb begin
    qd     = QDW'(s4_q0_q) * QDW'(D);
    rem    = s4_a_q - AW'(qd);
    q_fix  = (rem >= AW'(D)) ? s4_q0_q + AW'(1) : s4_q0_q;
    q_sat  = (q_fix > ONE_A) ? ONE_A : q_fix;
    p_next = s4_neg_q ? -$signed(PW'(q_sat)) : $signed(PW'(q_sat));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
      s5_valid_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_act_q  <= (n_i > NBW'(J));
      s1_neg_q  <= x_i[PW-1] ^ pc_i[PW-1];
      s1_n_q    <= n_i;
      s1_x_q    <= x_i;
      s1_pp_q   <= pp_i;
      s1_pc_q   <= pc_i;
      s1_dpp_q  <= dpp_i;
      s1_dpc_q  <= dpc_i;
      s1_prod_q <= PRW'(ua) * PRW'(ub);

      // history moves up here already when the step is live
      s2_act_q <= s1_act_q;
      s2_neg_q <= num[NW-1];
      s2_n_q   <= s1_n_q;
      s2_x_q   <= s1_x_q;
      s2_pp_q  <= s1_act_q ? s1_pc_q : s1_pp_q;
      s2_pc_q  <= s1_pc_q;
      s2_dpp_q <= s1_act_q ? s1_dpc_q : s1_dpp_q;
      s2_dpc_q <= s1_act_q ? DW'(dclamp) : s1_dpc_q;
      s2_a_q   <= a_val;

      s3_act_q <= s2_act_q;
      s3_neg_q <= s2_neg_q;
      s3_n_q   <= s2_n_q;
      s3_x_q   <= s2_x_q;
      s3_pp_q  <= s2_pp_q;
      s3_pc_q  <= s2_pc_q;
      s3_dpp_q <= s2_dpp_q;
      s3_dpc_q <= s2_dpc_q;
      s3_a_q   <= s2_a_q;
      s3_hh_q  <= (2*AH)'(s2_a_q[AW-1:AL]) * (2*AH)'(R_H);
      s3_hl_q  <= AW'(s2_a_q[AW-1:AL]) * AW'(R_L);
      s3_lh_q  <= AW'(s2_a_q[AL-1:0]) * AW'(R_H);
      s3_ll_q  <= (2*AL)'(s2_a_q[AL-1:0]) * (2*AL)'(R_L);

      s4_act_q <= s3_act_q;
      s4_neg_q <= s3_neg_q;
      s4_n_q   <= s3_n_q;
      s4_x_q   <= s3_x_q;
      s4_pp_q  <= s3_pp_q;
      s4_pc_q  <= s3_pc_q;
      s4_dpp_q <= s3_dpp_q;
      s4_dpc_q <= s3_dpc_q;
      s4_a_q   <= s3_a_q;
      s4_q0_q  <= AW'(qsum >> AW);

      s5_n_q   <= s4_n_q;
      s5_x_q   <= s4_x_q;
      s5_pp_q  <= s4_pp_q;
      s5_pc_q  <= s4_act_q ? p_next : s4_pc_q;
      s5_dpp_q <= s4_dpp_q;
      s5_dpc_q <= s4_dpc_q;
    end
  end

  assign valid_o = s5_valid_q;
  assign n_o     = s5_n_q;
  assign x_o     = s5_x_q;
  assign pp_o    = s5_pp_q;
  assign pc_o    = s5_pc_q;
  assign dpp_o   = s5_dpp_q;
  assign dpc_o   = s5_dpc_q;

endmodule

>>> sv/legendre_poly_and_derivative.sv
// Top level: Legendre P_N(x) and P'_N(x) through a chain of recurrence cells.
//
//   channel  direction  handshake                fields
//   cfg      in         cfg_valid_i/cfg_ready_o  cfg_degree_i
//   in       in         in_valid_i/in_stall_o    x_point_i
//   out      out        out_valid_o/out_stall_i  poly_value_o, deriv_value_o
//
// One point per cycle while the output is not stalled; each point passes the
// front register, five stages per cell for MAX_DEGREE-1 cells, and the output word.
// The cell depth is set by the x*P_j product and the split reciprocal divide.
// Reset empties the pipeline and sets the degree to one.
// A stalled output word freezes the whole chain; in_stall_o follows.
module legendre_poly_and_derivative #(
  parameter int MAX_DEGREE = lpd_pkg::MAX_DEGREE,
  parameter int FRAC_BITS  = lpd_pkg::FRAC_BITS
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic        [lpd_pkg::DEGREE_W-1:0]   cfg_degree_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [lpd_pkg::X_W-1:0]        x_point_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [lpd_pkg::POLY_W-1:0]     poly_value_o,
  output logic signed [lpd_pkg::DERIV_W-1:0]    deriv_value_o
);

  localparam int PW      = lpd_pkg::poly_w(FRAC_BITS);
  localparam int DW      = lpd_pkg::deriv_w(FRAC_BITS, MAX_DEGREE);
  localparam int NBW     = lpd_pkg::sel_w(MAX_DEGREE);
  localparam int NC      = MAX_DEGREE - 1;
  localparam int POLY_W  = lpd_pkg::POLY_W;
  localparam int DERIV_W = lpd_pkg::DERIV_W;

  logic [lpd_pkg::DEGREE_W-1:0] degree_q;
  logic                         en;
  logic                         out_valid_q;
  logic signed [POLY_W-1:0]     poly_q;
  logic signed [DERIV_W-1:0]    deriv_q;

  logic                  c_valid [NC+1];
  logic        [NBW-1:0] c_n     [NC+1];
  logic signed [PW-1:0]  c_x     [NC+1];
  logic signed [PW-1:0]  c_pp    [NC+1];
  logic signed [PW-1:0]  c_pc    [NC+1];
  logic signed [DW-1:0]  c_dpp   [NC+1];
  logic signed [DW-1:0]  c_dpc   [NC+1];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degree_q <= lpd_pkg::DEGREE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      degree_q <= cfg_degree_i;
    end
  end

  // chain moves unless a finished word is held up
  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  lpd_front #(
    .MAX_DEGREE (MAX_DEGREE),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (in_valid_i),
    .x_point_i (x_point_i),
    .degree_i  (degree_q),
    .valid_o   (c_valid[0]),
    .n_o       (c_n[0]),
    .x_o       (c_x[0]),
    .pp_o      (c_pp[0]),
    .pc_o      (c_pc[0]),
    .dpp_o     (c_dpp[0]),
    .dpc_o     (c_dpc[0])
  );

  for (genvar k = 0; k < NC; k++) begin : g_cell
    lpd_cell #(
      .J          (k + 1),
      .MAX_DEGREE (MAX_DEGREE),
      .FRAC_BITS  (FRAC_BITS)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (c_valid[k]),
      .n_i     (c_n[k]),
      .x_i     (c_x[k]),
      .pp_i    (c_pp[k]),
      .pc_i    (c_pc[k]),
      .dpp_i   (c_dpp[k]),
      .dpc_i   (c_dpc[k]),
      .valid_o (c_valid[k+1]),
      .n_o     (c_n[k+1]),
      .x_o     (c_x[k+1]),
      .pp_o    (c_pp[k+1]),
      .pc_o    (c_pc[k+1]),
      .dpp_o   (c_dpp[k+1]),
      .dpc_o   (c_dpc[k+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= c_valid[NC];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      poly_q  <= POLY_W'(c_pc[NC]);
      deriv_q <= DERIV_W'(c_dpc[NC]);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign poly_value_o  = poly_q;
  assign deriv_value_o = deriv_q;

endmodule

>>> sim/tb.sv
// Self-checking testbench for the Legendre P_N(x) / P'_N(x) evaluator.
`timescale 1ns / 1ps

module tb;

  localparam int     FRAC_BITS  = lpd_pkg::FRAC_BITS;
  localparam int     MAX_DEGREE = lpd_pkg::MAX_DEGREE;
  localparam int     X_W        = lpd_pkg::X_W;
  localparam int     POLY_W     = lpd_pkg::POLY_W;
  localparam int     DERIV_W    = lpd_pkg::DERIV_W;
  localparam int     DEGREE_W   = lpd_pkg::DEGREE_W;

  localparam longint ONE     = longint'(1) << FRAC_BITS;
  localparam int     HALF    = FRAC_BITS / 2;
  localparam int     LATENCY = 5 * MAX_DEGREE - 3;
  localparam int     IDLE_PCT = 28;
  localparam int     HOLD_CYCLES = 600;
  localparam int     LIMIT = 200000;

  typedef struct {
    logic signed [POLY_W-1:0]  poly;
    logic signed [DERIV_W-1:0] deriv;
  } legendre_pair_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                       cfg_valid_i  = 1'b0;
  logic                       cfg_ready_o;
  logic [DEGREE_W-1:0]        cfg_degree_i = '0;
  logic                       in_valid_i   = 1'b0;
  logic                       in_stall_o;
  logic signed [X_W-1:0]      x_point_i    = '0;
  logic                       out_valid_o;
  logic                       out_stall_i  = 1'b0;
  logic signed [POLY_W-1:0]   poly_value_o;
  logic signed [DERIV_W-1:0]  deriv_value_o;

  logic signed [X_W-1:0] x_pending[$];
  legendre_pair_t        pending_pairs[$];
  logic [DEGREE_W-1:0]   degree_shadow = lpd_pkg::DEGREE_RST;

  bit calm      = 1'b0;
  bit hold_req  = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;

  int errors       = 0;
  int points_sent  = 0;
  int words_seen   = 0;
  int stall_cycles = 0;
  int cycles       = 0;

  legendre_poly_and_derivative dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_degree_i  (cfg_degree_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .x_point_i     (x_point_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .poly_value_o  (poly_value_o),
    .deriv_value_o (deriv_value_o)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint unsigned abs_u(input longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  // x * p scaled back by 2^FRAC_BITS, split multiply, ties away from zero
  function automatic longint mul_round(input longint a, input longint b);
    longint unsigned ua, ub, bh, bl, hi, lo, m;
    ua = abs_u(a);
    ub = abs_u(b);
    bh = ub >> HALF;
    bl = ub & ((64'd1 << HALF) - 1);
    hi = ua * bh;
    lo = ua * bl + (64'd1 << (FRAC_BITS - 1));
    m  = (hi + (lo >> HALF)) >> (FRAC_BITS - HALF);
    return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint div_round(input longint n, input longint unsigned d);
    longint unsigned m;
    m = (abs_u(n) + d / 2) / d;
    return n < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint sat(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // three-term recurrence up to the configured degree
  function automatic legendre_pair_t legendre_eval(input logic signed [X_W-1:0] x_raw,
                                                   input logic [DEGREE_W-1:0] deg);
    legendre_pair_t r;
    longint x, p_prev, p_cur, p_next, dp_prev, dp_cur, dp_next, t, num, dlim, j, n;
    x = sat(longint'(x_raw), ONE);
    n = (deg > MAX_DEGREE) ? MAX_DEGREE : deg;
    p_prev  = ONE;
    p_cur   = x;
    dp_prev = 0;
    dp_cur  = ONE;
    if (n == 0) begin
      p_cur  = ONE;
      dp_cur = 0;
    end
    for (j = 1; j < n; j++) begin
      t       = mul_round(x, p_cur);
      num     = (2 * j + 1) * t - j * p_prev;
      p_next  = sat(div_round(num, j + 1), ONE);
      dlim    = ((j + 1) * (j + 2) / 2) * ONE;
      dp_next = sat((2 * j + 1) * p_cur + dp_prev, dlim);
      p_prev  = p_cur;
      p_cur   = p_next;
      dp_prev = dp_cur;
      dp_cur  = dp_next;
    end
    r.poly  = p_cur[POLY_W-1:0];
    r.deriv = dp_cur[DERIV_W-1:0];
    return r;
  endfunction

  function automatic logic signed [X_W-1:0] random_point();
    longint v;
    case ($urandom_range(9))
      0: v = longint'($signed($urandom()));
      1: v = ONE + 128 - longint'($urandom_range(0, 255));
      2: v = longint'(1) << $urandom_range(0, FRAC_BITS);
      default: v = longint'($urandom_range(0, 32'h8000_0000)) - ONE;
    endcase
    if ($urandom_range(1) == 1 && $urandom_range(9) != 0) v = -v;
    return v[X_W-1:0];
  endfunction

  // sender: holds the offered word until it is taken
  always @(posedge clk) begin
    if (in_valid_i && in_stall_o) stall_cycles <= stall_cycles + 1;
    if (in_valid_i && !in_stall_o) begin
      pending_pairs.push_back(legendre_eval(x_point_i, degree_shadow));
      void'(x_pending.pop_front());
      points_sent <= points_sent + 1;
    end
    if (!in_valid_i || !in_stall_o) begin
      if (x_pending.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        in_valid_i <= 1'b1;
        x_point_i  <= x_pending[0];
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (hold_req && !hold_done) begin
      hold_left   <= HOLD_CYCLES;
      hold_done   <= 1'b1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin : result_check
    legendre_pair_t want;
    int bad;
    bad = 0;
    if (out_valid_o && !out_stall_i) begin
      words_seen <= words_seen + 1;
      if (pending_pairs.size() == 0) begin
        $error("unexpected result word: poly_value %0d deriv_value %0d",
               poly_value_o, deriv_value_o);
        bad++;
      end else begin
        want = pending_pairs.pop_front();
        if (poly_value_o !== want.poly) begin
          $error("poly_value: expected %0d, got %0d", want.poly, poly_value_o);
          bad++;
        end
        if (deriv_value_o !== want.deriv) begin
          $error("deriv_value: expected %0d, got %0d", want.deriv, deriv_value_o);
          bad++;
        end
      end
    end
    if (bad != 0) errors <= errors + bad;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles,
               pending_pairs.size());
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic drain();
    while (x_pending.size() != 0 || pending_pairs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_degree(input logic [DEGREE_W-1:0] d);
    @(posedge clk);
    cfg_degree_i <= d;
    cfg_valid_i  <= 1'b1;
    do @(posedge clk); while (!cfg_ready_o);
    cfg_valid_i   <= 1'b0;
    degree_shadow = d;
  endtask

  task automatic run_random(input int count, input logic [DEGREE_W-1:0] d);
    write_degree(d);
    @(negedge clk);
    for (int i = 0; i < count; i++) x_pending.push_back(random_point());
    drain();
  endtask

  initial begin : stimulus
    logic signed [X_W-1:0] corner[12];
    int settings;
    corner = '{32'sd0, 32'sd1073741824, -32'sd1073741824, 32'sd1073741825,
               -32'sd1073741825, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd1, -32'sd1,
               32'sd536870912, -32'sd536870912, 32'sh1555_5555};
    settings = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corners at the reset degree, then at degree zero
    @(negedge clk);
    foreach (corner[i]) x_pending.push_back(corner[i]);
    drain();
    write_degree('0);
    @(negedge clk);
    foreach (corner[i]) x_pending.push_back(corner[i]);
    drain();
    settings = 2;

    run_random(100, DEGREE_W'(MAX_DEGREE));
    run_random(60, DEGREE_W'(2));
    settings += 2;

    // long output hold-off with a steady sender: the chain fills and stalls input
    write_degree(DEGREE_W'($urandom_range(3, 62)));
    @(negedge clk);
    calm     = 1'b1;
    hold_req = 1'b1;
    for (int i = 0; i < 350; i++) x_pending.push_back(random_point());
    drain();
    @(negedge clk);
    calm = 1'b0;
    settings++;

    repeat (6) begin
      run_random(60, DEGREE_W'($urandom_range(0, MAX_DEGREE)));
      settings++;
    end

    repeat (LATENCY + 20) @(posedge clk);
    $display("Covered %0d points over %0d degree settings (0, 1, 2, 63 and random),",
             points_sent, settings);
    $display("%0d result words checked; input held off for %0d cycles.", words_seen,
             stall_cycles);
    if (errors == 0 && pending_pairs.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/lpd_pkg.sv
sv/lpd_front.sv
sv/lpd_cell.sv
sv/legendre_poly_and_derivative.sv
sim/tb.sv
